// ----- sv/nearest_call_dispatcher_unit_macros.svh -----
// Assertion macros for the nearest call dispatcher.
`ifndef NEAREST_CALL_DISPATCHER_UNIT_MACROS_SVH
`define NEAREST_CALL_DISPATCHER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define NCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ncd assertion failed");

// Next-cycle implication, disabled during reset.
`define NCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ncd assertion failed");

`else

`define NCD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/ncd_pkg.sv -----
package ncd_pkg;

    localparam int NCD_MAX_FLOORS = 32;
    localparam int SERVED_CNT_W   = 6;
    localparam int FLOOR_W        = 8;
    localparam int OUT_FIELD_W    = 6;

    typedef enum logic [1:0] {
        REQ_HALL  = 2'd0,
        REQ_CAR   = 2'd1,
        REQ_DONE  = 2'd2,
        REQ_QUERY = 2'd3
    } req_type_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [FLOOR_W-1:0] call_floor;
        logic [FLOOR_W-1:0] car_floor;
    } ncd_req_t;

    typedef struct packed {
        logic                   accepted;
        logic                   target_valid;
        logic [OUT_FIELD_W-1:0] target_floor;
        logic [OUT_FIELD_W-1:0] pending_count;
    } ncd_rsp_t;

    // Microprogram step addresses
    typedef logic [1:0] step_t;
    localparam step_t STEP_IDLE   = 2'd0;
    localparam step_t STEP_UPDATE = 2'd1;
    localparam step_t STEP_SCAN   = 2'd2;
    localparam step_t STEP_LOAD   = 2'd3;

    typedef enum logic [1:0] {
        COND_NEVER    = 2'd0,
        COND_NO_REQ   = 2'd1,
        COND_SCAN_END = 2'd2,
        COND_RSP_BUSY = 2'd3
    } cond_t;

    typedef struct packed {
        cond_t cond;        // when true: jump, no actions
        step_t jump_step;
        step_t next_step;   // otherwise: do actions, go here
        logic  take_req;
        logic  do_update;
        logic  scan_init;
        logic  scan_step;
        logic  load_rsp;
    } ctrl_word_t;

    function automatic ctrl_word_t ctrl_rom(step_t step);
        ctrl_word_t w;
        w = '0;
        unique case (step)
            STEP_IDLE:
            begin
                w.cond      = COND_NO_REQ;
                w.jump_step = STEP_IDLE;
                w.next_step = STEP_UPDATE;
                w.take_req  = 1'b1;
            end
            STEP_UPDATE:
            begin
                w.cond      = COND_NEVER;
                w.jump_step = STEP_UPDATE;
                w.next_step = STEP_SCAN;
                w.do_update = 1'b1;
                w.scan_init = 1'b1;
            end
            STEP_SCAN:
            begin
                w.cond      = COND_SCAN_END;
                w.jump_step = STEP_LOAD;
                w.next_step = STEP_SCAN;
                w.scan_step = 1'b1;
            end
            STEP_LOAD:
            begin
                w.cond      = COND_RSP_BUSY;
                w.jump_step = STEP_LOAD;
                w.next_step = STEP_IDLE;
                w.load_rsp  = 1'b1;
            end
            default:
            begin
                w = '0;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- sv/nearest_call_dispatcher_unit.sv -----
// Channel   Signals                          Direction  Content
// req       req_valid / req_ready / req      in         request type, call floor, car floor
// rsp       rsp_valid / rsp_ready / rsp      out        accepted, target, pending count
// cfg       cfg_valid / cfg_ready / cfg_data in         served floor count register
//
// One transaction runs in order: capture, update, a floor-by-floor scan of the call bits
// (one floor per cycle), and a load step.
// The response register lets the next request be captured while a result waits.
// Reset (rst_n low, asynchronous) clears all call bits and sets the served floor count
// to min(32, MAX_FLOORS). A stalled response holds the sequencer in its load step.
`include "nearest_call_dispatcher_unit_macros.svh"

module nearest_call_dispatcher_unit
    import ncd_pkg::*;
#(
    parameter int MAX_FLOORS = NCD_MAX_FLOORS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  ncd_req_t                req,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output ncd_rsp_t                rsp,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [SERVED_CNT_W-1:0] cfg_data
);

    localparam int IW = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;
    localparam int FW = $clog2(MAX_FLOORS + 2);
    localparam int CW = $clog2(MAX_FLOORS + 1);
    localparam int DW = FLOOR_W + 1;
    localparam int FC_RESET = (MAX_FLOORS < 32) ? MAX_FLOORS : 32;

    step_t                    step_reg, step_next;
    logic [SERVED_CNT_W-1:0]  floors_served_reg;
    logic [MAX_FLOORS-1:0]    hall_reg;
    logic [MAX_FLOORS-1:0]    car_reg;
    ncd_req_t                 item_reg;
    logic                     accepted_reg;
    logic [FW-1:0]            scan_floor_reg;
    logic [CW-1:0]            count_reg;
    logic                     found_reg;
    logic [FW-1:0]            best_floor_reg;
    logic [DW-1:0]            best_dist_reg;
    logic                     rsp_valid_reg;
    ncd_rsp_t                 rsp_reg;

    ctrl_word_t               ctrl;
    logic                     cond_true;
    logic                     act;
    logic                     in_range;
    logic [FLOOR_W-1:0]       call_idx_full;
    logic [IW-1:0]            call_idx;
    logic [FW-1:0]            scan_idx_full;
    logic [IW-1:0]            scan_idx;
    logic                     scan_end;
    logic                     scan_pend;
    logic [DW-1:0]            cur_ext;
    logic [DW-1:0]            floor_ext;
    logic [DW-1:0]            floor_dist;
    logic                     better;

    assign ctrl = ctrl_rom(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_NO_REQ:   cond_true = !req_valid;
            COND_SCAN_END: cond_true = scan_end;
            COND_RSP_BUSY: cond_true = rsp_valid_reg && !rsp_ready;
            default:       cond_true = 1'b0;
        endcase
    end

    assign act       = !cond_true;
    assign step_next = cond_true ? ctrl.jump_step : ctrl.next_step;

    assign req_ready = ctrl.take_req;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Update path: call floor against the configured range
    assign in_range      = (item_reg.call_floor != '0)
                        && (item_reg.call_floor <= FLOOR_W'(floors_served_reg));
    assign call_idx_full = item_reg.call_floor - FLOOR_W'(1);
    assign call_idx      = call_idx_full[IW-1:0];

    // Scan path
    assign scan_end      = scan_floor_reg > FW'(floors_served_reg);
    assign scan_idx_full = scan_floor_reg - FW'(1);
    assign scan_idx      = scan_idx_full[IW-1:0];
    assign scan_pend     = hall_reg[scan_idx] || car_reg[scan_idx];
    assign cur_ext       = DW'(item_reg.car_floor);
    assign floor_ext     = DW'(scan_floor_reg);
    assign floor_dist    = (cur_ext > floor_ext) ? (cur_ext - floor_ext)
                                                 : (floor_ext - cur_ext);
    assign better        = !found_reg || (floor_dist < best_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg          <= STEP_IDLE;
            rsp_valid_reg     <= 1'b0;
            floors_served_reg <= SERVED_CNT_W'(FC_RESET);
            hall_reg          <= '0;
            car_reg           <= '0;
        end
        else
        begin
            step_reg <= step_next;

            if (cfg_valid && cfg_ready)
            begin
                if (int'(cfg_data) > MAX_FLOORS)
                    floors_served_reg <= SERVED_CNT_W'(MAX_FLOORS);
                else
                    floors_served_reg <= cfg_data;
            end

            if (act && ctrl.do_update && in_range)
            begin
                unique case (req_type_t'(item_reg.req_type))
                    REQ_HALL:  hall_reg[call_idx] <= 1'b1;
                    REQ_CAR:   car_reg[call_idx]  <= 1'b1;
                    REQ_DONE:
                    begin
                        hall_reg[call_idx] <= 1'b0;
                        car_reg[call_idx]  <= 1'b0;
                    end
                    REQ_QUERY: ;
                    default: ;
                endcase
            end

            // Drop the response once taken, refill from the load step
            if (act && ctrl.load_rsp)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act && ctrl.take_req)
            item_reg <= req;

        if (act && ctrl.do_update)
            accepted_reg <= (req_type_t'(item_reg.req_type) == REQ_QUERY) || in_range;

        if (act && ctrl.scan_init)
        begin
            scan_floor_reg <= FW'(1);
            count_reg      <= '0;
            found_reg      <= 1'b0;
            best_floor_reg <= '0;
            best_dist_reg  <= '0;
        end
        else if (act && ctrl.scan_step)
        begin
            scan_floor_reg <= scan_floor_reg + FW'(1);
            if (scan_pend)
            begin
                count_reg <= count_reg + CW'(1);
                if (better)
                begin
                    found_reg      <= 1'b1;
                    best_floor_reg <= scan_floor_reg;
                    best_dist_reg  <= floor_dist;
                end
            end
        end

        if (act && ctrl.load_rsp)
        begin
            rsp_reg.accepted      <= accepted_reg;
            rsp_reg.target_valid  <= found_reg;
            rsp_reg.target_floor  <= found_reg ? OUT_FIELD_W'(best_floor_reg) : '0;
            rsp_reg.pending_count <= OUT_FIELD_W'(count_reg);
        end
    end

    `NCD_ASSERT_NEXT(a_req_starts_update, clk, rst_n, req_valid && req_ready, step_reg == STEP_UPDATE)
    `NCD_ASSERT_IMPL(a_rsp_from_load, clk, rst_n, $rose(rsp_valid_reg), $past(step_reg) == STEP_LOAD)
    `NCD_ASSERT_IMPL(a_scan_bounded, clk, rst_n, step_reg == STEP_SCAN, scan_floor_reg <= FW'(floors_served_reg) + FW'(1))
    `NCD_ASSERT_IMPL(a_no_target_zero, clk, rst_n, rsp_valid && !rsp.target_valid, rsp.target_floor == '0 && rsp.pending_count == '0)
    `NCD_ASSERT_IMPL(a_rsp_held_in_load, clk, rst_n, rsp_valid_reg && !rsp_ready && step_reg == STEP_LOAD, step_next == STEP_LOAD)

endmodule
